// ===== rtl/twil_pkg.sv =====
// Shared constants and types of the table walk interpolation lookup unit.
package twil_pkg;

    localparam int DEF_NUM_WIRES     = 8;
    localparam int DEF_POSITION_BINS = 181;
    localparam int DEF_MAX_ENTRIES   = 64;

    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_APPEND = 2'd1;
    localparam logic [1:0] FUNC_LOOKUP = 2'd2;
    localparam logic [1:0] FUNC_NOP    = 2'd3;

    localparam logic [2:0] STAT_EXACT    = 3'd0;
    localparam logic [2:0] STAT_INTERP   = 3'd1;
    localparam logic [2:0] STAT_NOTFOUND = 3'd2;
    localparam logic [2:0] STAT_RANGE    = 3'd3;
    localparam logic [2:0] STAT_EMPTY    = 3'd4;

    typedef struct packed {
        logic [15:0] energy;
        logic [15:0] cm;
        logic [14:0] angle;
        logic [15:0] range;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== rtl/twil_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module twil_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/table_walk_interpolation_lookup_unit.sv =====
// Top level: per-wire, per-bin entry lists with walk and linear interpolation.
// Lookups walk the list from its middle entry and interpolate; the serial divisions
// use a restoring divider, one bit a cycle.
// One item at a time; an accepted append returns to idle after its length read and
// check, and the output register lets the next item in while a result waits.
// Reset and the clear command hold off input while every list length is cleared.
module table_walk_interpolation_lookup_unit
    import twil_pkg::*;
#(
    parameter int NUM_WIRES     = DEF_NUM_WIRES,
    parameter int POSITION_BINS = DEF_POSITION_BINS,
    parameter int MAX_ENTRIES   = DEF_MAX_ENTRIES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [3:0]  wire_index,
    input  logic signed [11:0] position_q4,
    input  logic [7:0]  position_bin,
    input  logic [15:0] target_energy_kev,
    input  logic [15:0] entry_energy_kev,
    input  logic [15:0] entry_cm_energy_kev,
    input  logic [14:0] entry_angle_q8,
    input  logic [15:0] entry_range_q8,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] cm_energy_kev,
    output logic [14:0] angle_q8,
    output logic [15:0] range_q8,
    output logic [2:0]  status
);

    localparam int NUM_LISTS = NUM_WIRES * POSITION_BINS;
    localparam int LW = $clog2(NUM_LISTS);
    localparam int EW = $clog2(NUM_LISTS * MAX_ENTRIES);
    localparam int NW = $clog2(MAX_ENTRIES + 1);
    localparam int IW = $clog2(MAX_ENTRIES);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_LEN, S_LENCHK, S_RD, S_CHK, S_MUL, S_DIV, S_ACC, S_DONE
    } state_t;

    state_t          state_reg;
    logic [LW-1:0]   clr_idx_reg;
    logic [LW-1:0]   list_reg;
    logic [EW-1:0]   base_reg;
    logic            append_reg;
    logic [15:0]     t_reg;
    entry_t          new_reg;
    logic [NW-1:0]   size_reg;
    logic [IW-1:0]   idx_reg;
    logic            mid_reg;
    logic            up_reg;
    entry_t          prev_reg;
    entry_t          cur_reg;
    logic [1:0]      k_reg;
    logic            neg_reg;
    logic [31:0]     quo_reg;
    logic [15:0]     rem_reg;
    logic [15:0]     den_reg;
    logic [4:0]      cnt_reg;
    logic [15:0]     res_cm_reg;
    logic [14:0]     res_ang_reg;
    logic [15:0]     res_rng_reg;
    logic [2:0]      res_stat_reg;
    logic            out_valid_reg;
    logic [15:0]     out_cm_reg;
    logic [14:0]     out_ang_reg;
    logic [15:0]     out_rng_reg;
    logic [2:0]      out_stat_reg;

    logic            len_we;
    logic [LW-1:0]   len_waddr;
    logic [NW-1:0]   len_wdata;
    logic [NW-1:0]   len_rdata;
    logic            ent_we;
    logic [EW-1:0]   ent_waddr;
    logic [EW-1:0]   ent_raddr;
    entry_t          ent_rdata;

    logic            accept;
    logic [11:0]     praw;
    logic [8:0]      qbin;
    logic            wire_ok;
    logic [3:0]      mapped;
    logic [LW-1:0]   lk_list;
    logic [LW-1:0]   ap_list;
    logic            lk_bad;
    logic            ap_bad;
    logic            step_end;
    logic [IW-1:0]   step_idx;
    logic            hit;
    logic [15:0]     vp;
    logic [15:0]     vt;
    logic [16:0]     diff;
    logic [15:0]     mag;
    logic [15:0]     mdist;
    logic [15:0]     ddist;
    logic [16:0]     shifted;
    logic            sub_ok;
    logic [16:0]     acc;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);

    assign praw = position_q4;
    always_comb
    begin
        if (praw[11])
        begin
            qbin = 9'((13'h1000 - {1'b0, praw}) >> 3);
        end
        else
        begin
            qbin = 9'(({1'b0, praw} + 13'd4) >> 3);
        end
    end

    assign wire_ok = ({1'b0, wire_index} < 5'(NUM_WIRES));
    always_comb
    begin
        case (wire_index)
            4'd3:    mapped = 4'd1;
            4'd4:    mapped = 4'd0;
            4'd7:    mapped = 4'd5;
            default: mapped = wire_index;
        endcase
    end

    assign lk_bad  = !wire_ok || (10'(qbin) > 10'(POSITION_BINS - 1));
    assign ap_bad  = !wire_ok || (10'(position_bin) >= 10'(POSITION_BINS));
    assign lk_list = LW'(LW'(mapped) * LW'(POSITION_BINS) + LW'(qbin));
    assign ap_list = LW'(LW'(wire_index) * LW'(POSITION_BINS) + LW'(position_bin));

    assign len_we    = (state_reg == S_CLR)
                       || (state_reg == S_LENCHK && append_reg
                           && len_rdata < NW'(MAX_ENTRIES));
    assign len_waddr = (state_reg == S_CLR) ? clr_idx_reg : list_reg;
    assign len_wdata = (state_reg == S_CLR) ? '0 : NW'(len_rdata + 1'b1);

    assign ent_we    = (state_reg == S_LENCHK) && append_reg
                       && len_rdata < NW'(MAX_ENTRIES);
    assign ent_waddr = base_reg + EW'(len_rdata[IW-1:0]);
    assign ent_raddr = base_reg + EW'(idx_reg);

    twil_ram #(.WIDTH(NW), .DEPTH(NUM_LISTS)) u_len_ram (
        .clk   (clk),
        .we    (len_we),
        .waddr (len_waddr),
        .wdata (len_wdata),
        .raddr (list_reg),
        .rdata (len_rdata)
    );

    twil_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_LISTS * MAX_ENTRIES)) u_ent_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (new_reg),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    // walk bounds and crossing test
    always_comb
    begin
        if (up_reg || mid_reg && ent_rdata.energy > t_reg)
        begin
            step_end = (NW'({1'b0, idx_reg}) + NW'(1)) >= size_reg;
            step_idx = idx_reg + 1'b1;
        end
        else
        begin
            step_end = (idx_reg == '0);
            step_idx = idx_reg - 1'b1;
        end
        hit = up_reg ? (ent_rdata.energy <= t_reg) : (ent_rdata.energy >= t_reg);
    end

    always_comb
    begin
        case (k_reg)
            2'd0:
            begin
                vp = prev_reg.cm;
                vt = cur_reg.cm;
            end
            2'd1:
            begin
                vp = {1'b0, prev_reg.angle};
                vt = {1'b0, cur_reg.angle};
            end
            default:
            begin
                vp = prev_reg.range;
                vt = cur_reg.range;
            end
        endcase
        diff    = {1'b0, vt} - {1'b0, vp};
        mag     = diff[16] ? 16'(-diff) : diff[15:0];
        mdist   = (t_reg >= prev_reg.energy) ? t_reg - prev_reg.energy
                                             : prev_reg.energy - t_reg;
        ddist   = (cur_reg.energy >= prev_reg.energy) ? cur_reg.energy - prev_reg.energy
                                                      : prev_reg.energy - cur_reg.energy;
        shifted = {rem_reg, quo_reg[31]};
        sub_ok  = shifted >= {1'b0, den_reg};
        acc     = neg_reg ? {1'b0, vp} - quo_reg[16:0] : {1'b0, vp} + quo_reg[16:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
            list_reg      <= '0;
            base_reg      <= '0;
            append_reg    <= 1'b0;
            t_reg         <= '0;
            new_reg       <= '0;
            size_reg      <= '0;
            idx_reg       <= '0;
            mid_reg       <= 1'b0;
            up_reg        <= 1'b0;
            prev_reg      <= '0;
            cur_reg       <= '0;
            k_reg         <= '0;
            neg_reg       <= 1'b0;
            quo_reg       <= '0;
            rem_reg       <= '0;
            den_reg       <= '0;
            cnt_reg       <= '0;
            res_cm_reg    <= '0;
            res_ang_reg   <= '0;
            res_rng_reg   <= '0;
            res_stat_reg  <= STAT_EXACT;
            out_cm_reg    <= '0;
            out_ang_reg   <= '0;
            out_rng_reg   <= '0;
            out_stat_reg  <= STAT_EXACT;
        end
        else
        begin
            if (out_valid_reg && out_ready && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLR:
                begin
                    if (clr_idx_reg == LW'(NUM_LISTS - 1))
                    begin
                        clr_idx_reg <= '0;
                        state_reg   <= S_IDLE;
                    end
                    else
                    begin
                        clr_idx_reg <= clr_idx_reg + 1'b1;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        t_reg       <= target_energy_kev;
                        new_reg     <= '{entry_energy_kev, entry_cm_energy_kev,
                                         entry_angle_q8, entry_range_q8};
                        res_cm_reg  <= '0;
                        res_ang_reg <= '0;
                        res_rng_reg <= '0;
                        case (func)
                            FUNC_CLEAR:
                            begin
                                state_reg <= S_CLR;
                            end
                            FUNC_APPEND:
                            begin
                                append_reg <= 1'b1;
                                list_reg   <= ap_list;
                                if (ap_bad)
                                begin
                                    res_stat_reg <= STAT_RANGE;
                                    state_reg    <= S_DONE;
                                end
                                else
                                begin
                                    state_reg <= S_LEN;
                                end
                            end
                            FUNC_LOOKUP:
                            begin
                                append_reg <= 1'b0;
                                list_reg   <= lk_list;
                                if (lk_bad)
                                begin
                                    res_stat_reg <= STAT_RANGE;
                                    state_reg    <= S_DONE;
                                end
                                else
                                begin
                                    state_reg <= S_LEN;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_LEN:
                begin
                    base_reg  <= EW'(EW'(list_reg) * EW'(MAX_ENTRIES));
                    state_reg <= S_LENCHK;
                end
                S_LENCHK:
                begin
                    if (append_reg)
                    begin
                        if (len_rdata >= NW'(MAX_ENTRIES))
                        begin
                            res_stat_reg <= STAT_EMPTY;
                            state_reg    <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                    else if (len_rdata == '0)
                    begin
                        res_stat_reg <= STAT_EMPTY;
                        state_reg    <= S_DONE;
                    end
                    else
                    begin
                        size_reg  <= len_rdata;
                        idx_reg   <= IW'(len_rdata >> 1);
                        mid_reg   <= 1'b1;
                        up_reg    <= 1'b0;
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    if (mid_reg && ent_rdata.energy == t_reg)
                    begin
                        res_cm_reg   <= ent_rdata.cm;
                        res_ang_reg  <= ent_rdata.angle;
                        res_rng_reg  <= ent_rdata.range;
                        res_stat_reg <= STAT_EXACT;
                        state_reg    <= S_DONE;
                    end
                    else if (!mid_reg && hit)
                    begin
                        cur_reg   <= ent_rdata;
                        k_reg     <= '0;
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        if (mid_reg)
                        begin
                            up_reg <= ent_rdata.energy > t_reg;
                        end
                        mid_reg  <= 1'b0;
                        prev_reg <= ent_rdata;
                        idx_reg  <= step_idx;
                        if (step_end)
                        begin
                            res_stat_reg <= STAT_NOTFOUND;
                            state_reg    <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_RD;
                        end
                    end
                end
                S_MUL:
                begin
                    neg_reg   <= diff[16];
                    quo_reg   <= mag * mdist;
                    den_reg   <= ddist;
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    rem_reg <= sub_ok ? 16'(shifted - {1'b0, den_reg}) : shifted[15:0];
                    quo_reg <= {quo_reg[30:0], sub_ok};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 5'd31)
                    begin
                        state_reg <= S_ACC;
                    end
                end
                S_ACC:
                begin
                    case (k_reg)
                        2'd0:    res_cm_reg  <= acc[15:0];
                        2'd1:    res_ang_reg <= acc[14:0];
                        default: res_rng_reg <= acc[15:0];
                    endcase
                    if (k_reg == 2'd2)
                    begin
                        res_stat_reg <= STAT_INTERP;
                        state_reg    <= S_DONE;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_MUL;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_cm_reg    <= res_cm_reg;
                        out_ang_reg   <= res_ang_reg;
                        out_rng_reg   <= res_rng_reg;
                        out_stat_reg  <= res_stat_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign cm_energy_kev = out_cm_reg;
    assign angle_q8      = out_ang_reg;
    assign range_q8      = out_rng_reg;
    assign status        = out_stat_reg;

endmodule

// ===== rtl/twil_checker.sv =====
// Port-level assertions for the lookup unit, bound to the top level.
module twil_checker
    import twil_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [1:0]  func,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] cm_energy_kev,
    input logic [14:0] angle_q8,
    input logic [15:0] range_q8,
    input logic [2:0]  status
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(cm_energy_kev))
        else $error("stalled result changed");

    a_zero_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STAT_EXACT && status != STAT_INTERP
        |-> cm_energy_kev == '0 && angle_q8 == '0 && range_q8 == '0)
        else $error("failed lookup carries nonzero values");

    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && func == FUNC_CLEAR |=> !in_ready)
        else $error("clear did not start clearing pass");

    a_reset_busy: assert property (@(posedge clk)
        $rose(rst_n) |-> !in_ready)
        else $error("ready during clearing pass after reset");

endmodule

bind table_walk_interpolation_lookup_unit twil_checker u_twil_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .func          (func),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .cm_energy_kev (cm_energy_kev),
    .angle_q8      (angle_q8),
    .range_q8      (range_q8),
    .status        (status)
);

// ===== test/tb_table_walk_interpolation_lookup_unit.sv =====
// Testbench of the table walk interpolation lookup unit: directed and random stimulus, scoreboard check.
module tb_table_walk_interpolation_lookup_unit;
    import twil_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NW = DEF_NUM_WIRES;
    localparam int NB = DEF_POSITION_BINS;
    localparam int NE = DEF_MAX_ENTRIES;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 400;

    typedef struct packed {
        logic [15:0] cm;
        logic [14:0] angle;
        logic [15:0] range;
        logic [2:0]  status;
    } lookup_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  func = FUNC_CLEAR;
    logic [3:0]  wire_index = '0;
    logic signed [11:0] position_q4 = '0;
    logic [7:0]  position_bin = '0;
    logic [15:0] target_energy_kev = '0;
    logic [15:0] entry_energy_kev = '0;
    logic [15:0] entry_cm_energy_kev = '0;
    logic [14:0] entry_angle_q8 = '0;
    logic [15:0] entry_range_q8 = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] cm_energy_kev;
    logic [14:0] angle_q8;
    logic [15:0] range_q8;
    logic [2:0]  status;

    table_walk_interpolation_lookup_unit u_dut (.*);

    always #1 clk = ~clk;

    int unsigned list_len [NW*NB];
    entry_t      list_entries [NW*NB][NE];
    lookup_result_t expected_results [$];
    int  mismatch_count = 0;
    bit  hold_off = 1'b0;
    int  idle_cycles = 0;

    function automatic logic [15:0] lerp(int vp, int vt, int ep, int et, int t, int maxv);
        longint num;
        longint den;
        longint v;
        num = longint'(vt - vp) * longint'(t - ep);
        den = et - ep;
        if (den == 0) return 16'((vt > maxv) ? maxv : vt);
        if (den < 0)
        begin
            den = -den;
            num = -num;
        end
        v = vp + num / den;
        if (v < 0) v = 0;
        if (v > maxv) v = maxv;
        return v[15:0];
    endfunction

    function automatic bit predict_lookup(logic [1:0] f, logic [3:0] w, logic [11:0] p,
                                          logic [7:0] pb, logic [15:0] t, entry_t ent,
                                          output lookup_result_t r);
        int bin;
        int m;
        int lst;
        int sz;
        int st;
        int dir;
        int i;
        entry_t prv;
        entry_t e;
        r = '0;
        if (f == FUNC_CLEAR)
        begin
            foreach (list_len[k]) list_len[k] = 0;
            return 0;
        end
        if (f == FUNC_APPEND)
        begin
            if (w >= NW || pb >= NB)
            begin
                r.status = STAT_RANGE;
                return 1;
            end
            lst = w * NB + pb;
            if (list_len[lst] >= NE)
            begin
                r.status = STAT_EMPTY;
                return 1;
            end
            list_entries[lst][list_len[lst]] = ent;
            list_len[lst]++;
            return 0;
        end
        if (f != FUNC_LOOKUP) return 0;
        if (p[11]) bin = ((13'h1000 - p) & 12'hFFF) >> 3;
        else bin = (p + 4) >> 3;
        if (w >= NW || bin > NB - 1)
        begin
            r.status = STAT_RANGE;
            return 1;
        end
        m = (w == 3) ? 1 : (w == 4) ? 0 : (w == 7) ? 5 : w;
        lst = m * NB + bin;
        sz = list_len[lst];
        if (sz == 0)
        begin
            r.status = STAT_EMPTY;
            return 1;
        end
        st = sz / 2;
        prv = list_entries[lst][st];
        if (prv.energy == t)
        begin
            r = {prv.cm, prv.angle, prv.range, STAT_EXACT};
            return 1;
        end
        dir = (prv.energy > t) ? 1 : -1;
        for (i = st + dir; i >= 0 && i < sz; i += dir)
        begin
            e = list_entries[lst][i];
            if ((dir < 0 && e.energy >= t) || (dir > 0 && e.energy <= t))
            begin
                r.cm = lerp(prv.cm, e.cm, prv.energy, e.energy, t, 16'hFFFF);
                r.angle = 15'(lerp(prv.angle, e.angle, prv.energy, e.energy, t, 16'h7FFF));
                r.range = lerp(prv.range, e.range, prv.energy, e.energy, t, 16'hFFFF);
                r.status = STAT_INTERP;
                return 1;
            end
            prv = e;
        end
        r.status = STAT_NOTFOUND;
        return 1;
    endfunction

    task automatic send_item(logic [1:0] f, logic [3:0] w, logic [11:0] p, logic [7:0] pb,
                             logic [15:0] t, entry_t ent);
        lookup_result_t r;
        func <= f;
        wire_index <= w;
        position_q4 <= p;
        position_bin <= pb;
        target_energy_kev <= t;
        entry_energy_kev <= ent.energy;
        entry_cm_energy_kev <= ent.cm;
        entry_angle_q8 <= ent.angle;
        entry_range_q8 <= ent.range;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        if (predict_lookup(f, w, p, pb, t, ent, r)) expected_results = {expected_results, r};
    endtask

    task automatic idle_gap(int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic entry_t rand_entry(logic [15:0] en);
        entry_t e;
        e.energy = en;
        e.cm = 16'($urandom);
        e.angle = 15'($urandom_range(0, 23040));
        e.range = 16'($urandom);
        return e;
    endfunction

    function automatic logic [11:0] pos_for_bin(int b);
        return ($urandom_range(0, 1)) ? 12'(b * 8) : 12'(-(b * 8) - $urandom_range(0, 7));
    endfunction

    task automatic test_directed();
        entry_t z;
        z = '0;
        send_item(FUNC_APPEND, 4'd8, 12'd0, 8'd0, 16'd0, rand_entry(16'hFFFF));
        send_item(FUNC_APPEND, 4'd15, 12'd0, 8'd255, 16'd0, rand_entry(16'd0));
        send_item(FUNC_APPEND, 4'd0, 12'd0, 8'd181, 16'd0, z);
        send_item(FUNC_LOOKUP, 4'd9, 12'd0, 8'd0, 16'd0, z);
        send_item(FUNC_LOOKUP, 4'd0, 12'h7FF, 8'd0, 16'd0, z);
        send_item(FUNC_LOOKUP, 4'd0, 12'h800, 8'd0, 16'd0, z);
        send_item(FUNC_LOOKUP, 4'd0, 12'd4, 8'd0, 16'd5, z);
        send_item(FUNC_APPEND, 4'd1, 12'd0, 8'd1, 16'd0, rand_entry(16'd3000));
        send_item(FUNC_APPEND, 4'd1, 12'd0, 8'd1, 16'd0, rand_entry(16'd2000));
        send_item(FUNC_APPEND, 4'd1, 12'd0, 8'd1, 16'd0, rand_entry(16'd1000));
        send_item(FUNC_LOOKUP, 4'd3, 12'd4, 8'd0, 16'd2000, z);
        send_item(FUNC_LOOKUP, 4'd1, 12'd8, 8'd0, 16'd1500, z);
        send_item(FUNC_LOOKUP, 4'd1, -12'sd11, 8'd0, 16'd2500, z);
        send_item(FUNC_LOOKUP, 4'd1, 12'd11, 8'd0, 16'd3000, z);
        send_item(FUNC_LOOKUP, 4'd1, 12'd8, 8'd0, 16'd0, z);
        send_item(FUNC_LOOKUP, 4'd1, 12'd8, 8'd0, 16'hFFFF, z);
        send_item(FUNC_LOOKUP, 4'd1, 12'd3, 8'd0, 16'd1000, z);
        send_item(FUNC_NOP, 4'd1, 12'd8, 8'd1, 16'd0, z);
        for (int i = 0; i < NE + 1; i++)
            send_item(FUNC_APPEND, 4'd7, 12'd0, 8'd180, 16'd0, rand_entry(16'(60000 - 900 * i)));
        send_item(FUNC_LOOKUP, 4'd7, 12'd1440, 8'd0, 16'd33333, z);
        send_item(FUNC_LOOKUP, 4'd7, -12'sd1447, 8'd0, 16'd20, z);
        wait_drained();
        send_item(FUNC_CLEAR, 4'd0, 12'd0, 8'd0, 16'd0, z);
        send_item(FUNC_LOOKUP, 4'd1, 12'd8, 8'd0, 16'd1500, z);
        wait_drained();
    endtask

    task automatic test_random(int n_items);
        int hot_bins [4];
        int sent;
        int b;
        int w;
        int burst;
        logic [15:0] en;
        entry_t z;
        z = '0;
        sent = 0;
        foreach (hot_bins[k]) hot_bins[k] = $urandom_range(0, NB - 1);
        hot_bins[0] = 0;
        hot_bins[1] = NB - 1;
        while (sent < n_items)
        begin
            burst = $urandom_range(1, 12);
            repeat (burst)
            begin
                b = hot_bins[$urandom_range(0, 3)];
                w = $urandom_range(0, NW - 1);
                case ($urandom_range(0, 19))
                    0:
                        begin
                            wait_drained();
                            send_item(FUNC_CLEAR, 4'($urandom), 12'($urandom), 8'($urandom),
                                      16'($urandom), z);
                        end
                    1, 2, 3, 4, 5, 6, 7:
                        begin
                            en = 16'($urandom);
                            if ($urandom_range(0, 3) != 0)
                                en = 16'(60000 - 937 * list_len[w * NB + b] + $urandom_range(0, 400));
                            send_item(FUNC_APPEND, 4'(w), 12'($urandom), 8'(b), 16'($urandom),
                                      rand_entry(en));
                        end
                    8:
                        send_item(FUNC_APPEND, 4'($urandom), 12'($urandom), 8'($urandom),
                                  16'($urandom), rand_entry(16'($urandom)));
                    9:
                        send_item(2'($urandom), 4'($urandom), 12'($urandom), 8'($urandom),
                                  16'($urandom), rand_entry(16'($urandom)));
                    default:
                        send_item(FUNC_LOOKUP,
                                  ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'(w),
                                  ($urandom_range(0, 9) == 0) ? 12'($urandom) : pos_for_bin(b),
                                  8'($urandom), ($urandom_range(0, 1)) ? 16'($urandom) :
                                  16'($urandom_range(0, 62000)), z);
                endcase
                sent++;
            end
            if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 30));
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        entry_t z;
        z = '0;
        hold_off = 1'b1;
        for (int i = 0; i < 12; i++)
            send_item(FUNC_LOOKUP, 4'($urandom_range(0, 15)), 12'($urandom), 8'd0,
                      16'($urandom), z);
        hold_off = 1'b0;
        wait_drained();
    endtask

    int hold_cnt = 0;
    always @(posedge clk)
    begin
        if (hold_off && hold_cnt < 3000)
        begin
            hold_cnt <= hold_cnt + 1;
            out_ready <= 1'b0;
        end
        else
        begin
            if (!hold_off) hold_cnt <= 0;
            out_ready <= ($urandom_range(0, 7) < 5) || hold_cnt >= 3000;
        end
    end

    always @(posedge clk)
    begin
        lookup_result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected result status=%0d", status);
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (exp_r != {cm_energy_kev, angle_q8, range_q8, status})
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch exp cm=%0d ang=%0d rng=%0d st=%0d got %0d %0d %0d %0d",
                                 exp_r.cm, exp_r.angle, exp_r.range, exp_r.status,
                                 cm_energy_kev, angle_q8, range_q8, status);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        foreach (list_len[k]) list_len[k] = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_backpressure();
        test_random(500);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/twil_pkg.sv
rtl/twil_ram.sv
rtl/table_walk_interpolation_lookup_unit.sv
rtl/twil_checker.sv
test/tb_table_walk_interpolation_lookup_unit.sv
